>>> hdl/crdg_pkg.sv
// Shared widths and the normalization payload type for the camera ray direction generator.
// No dependencies; imported by every module of the block.
package crdg_pkg;

	localparam int COMP_W   = 20;             // corner component, signed Q2.17
	localparam int CORNER_W = 3 * COMP_W;     // packed x,y,z corner
	localparam int DIM_W    = 13;             // frame width / height register
	localparam int POS_W    = 16;             // screen position, unsigned Q12.4
	localparam int V_W      = 54;             // unnormalized grid vector component
	localparam int MAGF_W   = V_W - 1;        // its magnitude
	localparam int MAG_W    = 30;             // magnitude after the range shift
	localparam int K_W      = 5;              // range shift amount
	localparam int SUM_W    = 62;             // sum of three squares
	localparam int ROOT_W   = 31;             // integer square root of the sum
	localparam int Q_W      = 17;             // quotient bits, up to 1.0 in Q1.16
	localparam int NUM_W    = MAG_W + 17;     // divide numerator m*2^16 + s/2
	localparam int OUT_W    = 18;             // direction component, signed Q1.16

	localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(65536);

	typedef struct packed {
		logic [2:0][MAG_W-1:0] m;
		logic [2:0]            neg;
	} norm_t;

endpackage

>>> hdl/crdg_grid.sv
// Grid stages: bilinear corner interpolation as one exact integer vector, sign and
// magnitude split, range shift and sum of squares. Depends on crdg_pkg.
module crdg_grid import crdg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [POS_W-1:0]    sx,
	input  logic [POS_W-1:0]    sy,
	input  logic [CORNER_W-1:0] tl,
	input  logic [CORNER_W-1:0] tr,
	input  logic [CORNER_W-1:0] bl,
	input  logic [DIM_W-1:0]    w,
	input  logic [DIM_W-1:0]    h,
	output logic                out_valid,
	output logic [SUM_W-1:0]    sum,
	output norm_t               norm
);

	localparam int DEPTH = 8;
	localparam int A_W   = COMP_W + DIM_W + 1;
	localparam int B_W   = COMP_W + 1 + POS_W + 1;
	localparam int PA_W  = A_W + DIM_W + 1;
	localparam int PB_W  = B_W + DIM_W + 1;

	logic [DEPTH:1] vld_s;

	logic [DIM_W-1:0] w_s1, h_s1;

	logic signed [A_W-1:0]  a_s1 [3];
	logic signed [B_W-1:0]  b_s1 [3];
	logic signed [B_W-1:0]  c_s1 [3];
	logic signed [PA_W-1:0] pa_s2 [3];
	logic signed [PB_W-1:0] pb_s2 [3];
	logic signed [PB_W-1:0] pc_s2 [3];
	logic signed [V_W-1:0]  v_s3 [3];
	logic [MAGF_W-1:0]      mag_s4 [3];
	logic [MAGF_W-1:0]      mag_s5 [3];
	logic [MAG_W-1:0]       m_s6 [3];
	logic [MAG_W-1:0]       m_s7 [3];
	logic [2*MAG_W-1:0]     sq_s7 [3];
	logic [2:0]             neg_s4, neg_s5, neg_s6, neg_s7;
	logic [K_W-1:0]         k_s5;
	norm_t                  norm_s8;
	logic [SUM_W-1:0]       sum_s8;

	logic [MAGF_W-1:0] mag_or;
	logic [K_W-1:0]    k_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DEPTH-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= w;
			h_s1 <= h;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [COMP_W-1:0] tl_c, tr_c, bl_c;
		logic signed [COMP_W:0]   dtr, dbl;

		assign tl_c = tl[i*COMP_W +: COMP_W];
		assign tr_c = tr[i*COMP_W +: COMP_W];
		assign bl_c = bl[i*COMP_W +: COMP_W];
		assign dtr  = $signed({tr_c[COMP_W-1], tr_c}) - $signed({tl_c[COMP_W-1], tl_c});
		assign dbl  = $signed({bl_c[COMP_W-1], bl_c}) - $signed({tl_c[COMP_W-1], tl_c});

		always_ff @(posedge clk) begin
			if (adv) begin
				a_s1[i]  <= tl_c * $signed({1'b0, h});
				b_s1[i]  <= dtr * $signed({1'b0, sx});
				c_s1[i]  <= dbl * $signed({1'b0, sy});
				pa_s2[i] <= a_s1[i] * $signed({1'b0, w_s1});
				pb_s2[i] <= b_s1[i] * $signed({1'b0, h_s1});
				pc_s2[i] <= c_s1[i] * $signed({1'b0, w_s1});
				// top-left term carries the Q12.4 scale of the position: times 16
				v_s3[i]  <= $signed({{(V_W-PA_W-4){pa_s2[i][PA_W-1]}}, pa_s2[i], 4'b0000})
				          + $signed({{(V_W-PB_W){pb_s2[i][PB_W-1]}}, pb_s2[i]})
				          + $signed({{(V_W-PB_W){pc_s2[i][PB_W-1]}}, pc_s2[i]});
				neg_s4[i] <= v_s3[i][V_W-1];
				mag_s4[i] <= v_s3[i][V_W-1] ? MAGF_W'(-v_s3[i]) : MAGF_W'(v_s3[i]);
				mag_s5[i] <= mag_s4[i];
				neg_s5[i] <= neg_s4[i];
				m_s6[i]   <= MAG_W'(mag_s5[i] >> k_s5);
				neg_s6[i] <= neg_s5[i];
				sq_s7[i]  <= m_s6[i] * m_s6[i];
				m_s7[i]   <= m_s6[i];
				neg_s7[i] <= neg_s6[i];
				norm_s8.m[i]   <= m_s7[i];
				norm_s8.neg[i] <= neg_s7[i];
			end
		end
	end

	// smallest shift that brings every magnitude below 2^MAG_W
	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		k_next = '0;
		for (int b = MAG_W; b < MAGF_W; b++) begin
			if (mag_or[b]) k_next = K_W'(b - MAG_W + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s5   <= k_next;
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	assign out_valid = vld_s[DEPTH];
	assign sum       = sum_s8;
	assign norm      = norm_s8;

endmodule

>>> hdl/crdg_sqrt.sv
// Pipelined integer square root, one root bit per stage, with the lane payload
// carried alongside. Depends on crdg_pkg.
module crdg_sqrt import crdg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  sum,
	input  norm_t             in_norm,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output norm_t             out_norm
);

	localparam int REM_W = ROOT_W + 1;
	localparam int CUR_W = REM_W + 2;

	logic [ROOT_W-1:0] vld_s;
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SUM_W-1:0]  n_s    [ROOT_W];
	norm_t             norm_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		logic              pv;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		logic [SUM_W-1:0]  pn;
		norm_t             pnorm;
		logic [CUR_W-1:0]  cur, trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign proot = '0;
			assign pn    = sum;
			assign pnorm = in_norm;
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign prem  = rem_s[j-1];
			assign proot = root_s[j-1];
			assign pn    = n_s[j-1];
			assign pnorm = norm_s[j-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign cur   = {prem, pn[SUM_W-1-2*j -: 2]};
		assign trial = CUR_W'({proot, 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
				root_s[j] <= {proot[ROOT_W-2:0], ge};
				n_s[j]    <= pn;
				norm_s[j] <= pnorm;
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_norm  = norm_s[ROOT_W-1];

endmodule

>>> hdl/crdg_div.sv
// Pipelined restoring divide of each lane magnitude, scaled to Q1.16 with rounding,
// by the vector length; one quotient bit per stage. Depends on crdg_pkg.
module crdg_div import crdg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [ROOT_W-1:0]     root,
	input  norm_t                 in_norm,
	output logic                  out_valid,
	output logic [2:0][Q_W-1:0]   quo,
	output logic [2:0]            neg,
	output logic                  zero
);

	logic [Q_W:0]      vld_s;
	logic [ROOT_W-1:0] s_s    [Q_W+1];
	logic [2:0]        neg_s  [Q_W+1];
	logic              zero_s [Q_W+1];
	logic [NUM_W-1:0]  num_s  [Q_W+1][3];
	logic [ROOT_W-1:0] r_s    [Q_W+1][3];
	logic [Q_W-1:0]    q_s    [Q_W+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[Q_W-1:0], in_valid};
		end
	end

	// numerator m*2^16 + floor(s/2) rounds the quotient half up
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s[0]    <= root;
			neg_s[0]  <= in_norm.neg;
			zero_s[0] <= root == '0;
			for (int i = 0; i < 3; i++) begin
				num_s[0][i] <= {in_norm.m[i], 16'b0} + NUM_W'(root >> 1);
				r_s[0][i]   <= ROOT_W'(0);
				q_s[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_stage
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [ROOT_W-1:0] pr;
			logic [ROOT_W:0]   cur;
			logic              ge;

			if (j == 1) begin : g_first
				assign pr = ROOT_W'(num_s[0][i][NUM_W-1:Q_W]);
			end else begin : g_next
				assign pr = r_s[j-1][i];
			end

			assign cur = {pr, num_s[j-1][i][Q_W-j]};
			assign ge  = cur >= {1'b0, s_s[j-1]};

			always_ff @(posedge clk) begin
				if (adv) begin
					r_s[j][i]   <= ge ? ROOT_W'(cur - {1'b0, s_s[j-1]}) : ROOT_W'(cur);
					q_s[j][i]   <= {q_s[j-1][i][Q_W-2:0], ge};
					num_s[j][i] <= num_s[j-1][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				s_s[j]    <= s_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign neg       = neg_s[Q_W];
	assign zero      = zero_s[Q_W];
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign quo[i] = q_s[Q_W][i];
	end

endmodule

>>> hdl/camera_ray_direction_generator_top.sv
// Camera ray direction generator: configuration registers, pipeline control and
// output register. Depends on crdg_pkg, crdg_grid, crdg_sqrt and crdg_div.
//
// Takes one screen position per cycle while not stalled and returns the unit ray
// direction through it after 8 grid stages (interpolation multiplies, sign split,
// range shift, squares and sum), 31 square root stages at one root bit each, 18
// divide stages (rounding add, then one quotient bit each) and output register.
// The pipeline keeps accepting while a result waits in the output register, until
// a finished beat reaches the last stage. Corner registers take 64-bit writes at
// byte address 8*i; write configuration only while no beat is in flight.
module camera_ray_direction_generator_top import crdg_pkg::*; #(
	parameter int FRAME_DIM_MAX = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [5:0]              paddr,
	input  logic [63:0]             pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [POS_W-1:0]        screen_x,
	input  logic [POS_W-1:0]        screen_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] dir_x,
	output logic signed [OUT_W-1:0] dir_y,
	output logic signed [OUT_W-1:0] dir_z
);

	typedef enum logic [2:0] {
		REG_TL = 3'd0,
		REG_TR = 3'd1,
		REG_BL = 3'd2,
		REG_W  = 3'd3,
		REG_H  = 3'd4
	} reg_idx_t;

	localparam logic [DIM_W-1:0] DIM_CAP =
		(FRAME_DIM_MAX > 8191) ? {DIM_W{1'b1}} : DIM_W'(FRAME_DIM_MAX);

	logic [CORNER_W-1:0] tl_q, tr_q, bl_q;
	logic [DIM_W-1:0]    w_q, h_q;
	logic [DIM_W-1:0]    w_eff, h_eff;
	logic [2:0]          ridx;
	logic                wr;

	logic                adv, out_load;
	logic                grid_valid, sqrt_valid, div_valid;
	logic [SUM_W-1:0]    grid_sum;
	norm_t               grid_norm, sqrt_norm;
	logic [ROOT_W-1:0]   root;
	logic [2:0][Q_W-1:0] quo;
	logic [2:0]          quo_neg;
	logic                quo_zero;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] dir_q [3];
	logic signed [OUT_W-1:0] dir_next [3];

	assign pready = 1'b1;
	assign ridx   = paddr[5:3];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= '0;
			tr_q <= '0;
			bl_q <= '0;
			w_q  <= DIM_W'(640);
			h_q  <= DIM_W'(480);
		end else if (wr) begin
			unique case (ridx)
				REG_TL:  tl_q <= pwdata[CORNER_W-1:0];
				REG_TR:  tr_q <= pwdata[CORNER_W-1:0];
				REG_BL:  bl_q <= pwdata[CORNER_W-1:0];
				REG_W:   w_q  <= pwdata[DIM_W-1:0];
				REG_H:   h_q  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_TL:  prdata = 64'(tl_q);
			REG_TR:  prdata = 64'(tr_q);
			REG_BL:  prdata = 64'(bl_q);
			REG_W:   prdata = 64'(w_q);
			REG_H:   prdata = 64'(h_q);
			default: prdata = '0;
		endcase
	end

	// a zero frame size counts as one pixel, an oversized one as the cap
	always_comb begin
		w_eff = (w_q == '0) ? DIM_W'(1) : ((w_q > DIM_CAP) ? DIM_CAP : w_q);
		h_eff = (h_q == '0) ? DIM_W'(1) : ((h_q > DIM_CAP) ? DIM_CAP : h_q);
	end

	// advance while the last stage is empty or the output register frees up
	assign out_load = !out_valid_q || !out_stall;
	assign adv      = !div_valid || out_load;
	assign in_stall = !adv;

	crdg_grid u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.sx        (screen_x),
		.sy        (screen_y),
		.tl        (tl_q),
		.tr        (tr_q),
		.bl        (bl_q),
		.w         (w_eff),
		.h         (h_eff),
		.out_valid (grid_valid),
		.sum       (grid_sum),
		.norm      (grid_norm)
	);

	crdg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (grid_valid),
		.sum       (grid_sum),
		.in_norm   (grid_norm),
		.out_valid (sqrt_valid),
		.root      (root),
		.out_norm  (sqrt_norm)
	);

	crdg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sqrt_valid),
		.root      (root),
		.in_norm   (sqrt_norm),
		.out_valid (div_valid),
		.quo       (quo),
		.neg       (quo_neg),
		.zero      (quo_zero)
	);

	// saturate to 1.0, apply sign, drop a zero-length vector to zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [Q_W-1:0] qs;
			qs = (quo[i] > UNIT_ONE) ? UNIT_ONE : quo[i];
			if (quo_zero) begin
				dir_next[i] = '0;
			end else if (quo_neg[i]) begin
				dir_next[i] = -$signed({1'b0, qs});
			end else begin
				dir_next[i] = $signed({1'b0, qs});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= dir_next[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dir_x     = dir_q[0];
	assign dir_y     = dir_q[1];
	assign dir_z     = dir_q[2];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipeline could advance");

	a_dir_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dir_x <= 18'sd65536 && dir_x >= -18'sd65536))
		else $error("dir_x beyond unit range");

	a_dir_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dir_z <= 18'sd65536 && dir_z >= -18'sd65536))
		else $error("dir_z beyond unit range");

endmodule
